>>> rtl/sfr_pkg.sv
// Shared types and constants for the serial frame receiver.
// Status codes, marker register set, result record and reset values.
// No dependencies.
package sfr_pkg;

  localparam int unsigned DEF_HEADER_BYTES       = 5;
  localparam int unsigned DEF_FRAME_BUFFER_BYTES = 64;
  localparam int unsigned TRAILER_BYTES          = 3;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned PIDX_W  = 6;
  localparam int unsigned PLEN_W  = 6;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] CHK_OFFSET = 8'hAD;
  localparam logic [BYTE_W-1:0] ZERO_BYTE  = 8'h00;

  localparam logic [BYTE_W-1:0] RST_PREFIX = 8'h07;
  localparam logic [BYTE_W-1:0] RST_HEAD   = 8'hF0;
  localparam logic [BYTE_W-1:0] RST_TAIL   = 8'h0F;
  localparam logic [BYTE_W-1:0] RST_ACK    = 8'hF3;

  localparam logic [CFG_IDX_W-1:0] CFG_PREFIX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK    = 2'd3;

  typedef enum logic [STAT_W-1:0] {
    ST_HEADER    = 3'd0,
    ST_PAYLOAD   = 3'd1,
    ST_ESCAPE    = 3'd2,
    ST_DONE      = 3'd3,
    ST_ACK       = 3'd4,
    ST_FRAMING   = 3'd5,
    ST_CHECKSUM  = 3'd6,
    ST_TOO_LARGE = 3'd7
  } sfr_status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] prefix;
    logic [BYTE_W-1:0] head;
    logic [BYTE_W-1:0] tail;
    logic [BYTE_W-1:0] ack;
  } sfr_markers_t;

  typedef struct packed {
    sfr_status_t       status;
    logic [BYTE_W-1:0] payload_byte;
    logic [PIDX_W-1:0] payload_index;
    logic [BYTE_W-1:0] command_id;
    logic [PLEN_W-1:0] payload_length;
  } sfr_result_t;

endpackage

>>> rtl/sfr_cfg_regs.sv
// Marker register file of the serial frame receiver.
// Write-only, reset to the default marker bytes. Depends on sfr_pkg.
module sfr_cfg_regs
  import sfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata,
  output sfr_markers_t         markers
);

  sfr_markers_t markers_r;
  sfr_markers_t markers_nxt;

  always_comb begin
    markers_nxt = markers_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_PREFIX: markers_nxt.prefix = cfg_wdata;
        CFG_HEAD:   markers_nxt.head   = cfg_wdata;
        CFG_TAIL:   markers_nxt.tail   = cfg_wdata;
        CFG_ACK:    markers_nxt.ack    = cfg_wdata;
        default:    markers_nxt = markers_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      markers_r.prefix <= RST_PREFIX;
      markers_r.head   <= RST_HEAD;
      markers_r.tail   <= RST_TAIL;
      markers_r.ack    <= RST_ACK;
    end else begin
      markers_r <= markers_nxt;
    end
  end

  assign markers = markers_r;

endmodule

>>> rtl/sfr_frame_ctrl.sv
// Frame position tracker: checks each byte against its place in the frame,
// keeps command, length, checksum and escape state. Depends on sfr_pkg.
module sfr_frame_ctrl
  import sfr_pkg::*;
#(
  parameter int unsigned HEADER_BYTES       = DEF_HEADER_BYTES,
  parameter int unsigned FRAME_BUFFER_BYTES = DEF_FRAME_BUFFER_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [BYTE_W-1:0] rx_byte,
  input  sfr_markers_t      markers,
  output sfr_result_t       res
);

  localparam int unsigned POS_W = $clog2(FRAME_BUFFER_BYTES);
  localparam int unsigned EXT_W = 10;

  logic [POS_W-1:0]  position_r, position_nxt;
  logic [BYTE_W-1:0] frame_length_r, frame_length_nxt;
  logic [BYTE_W-1:0] command_r, command_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic              prev_prefix_r, prev_prefix_nxt;

  logic [EXT_W-1:0]  pos_ext;
  logic [EXT_W-1:0]  pay_end;
  logic [EXT_W-1:0]  pidx_ext;
  logic              too_large;
  logic              is_prefix;

  assign pos_ext   = EXT_W'(position_r);
  assign pay_end   = EXT_W'(HEADER_BYTES) + EXT_W'(frame_length_r);
  assign pidx_ext  = pos_ext - EXT_W'(HEADER_BYTES);
  assign too_large = (pay_end + EXT_W'(TRAILER_BYTES)) > EXT_W'(FRAME_BUFFER_BYTES);
  assign is_prefix = (rx_byte == markers.prefix);

  always_comb begin
    position_nxt     = position_r;
    frame_length_nxt = frame_length_r;
    command_nxt      = command_r;
    sum_nxt          = sum_r;
    prev_prefix_nxt  = prev_prefix_r;
    res              = '0;
    res.status       = ST_HEADER;

    if (position_r == '0) begin
      if (is_prefix) begin
        position_nxt = POS_W'(1);
        sum_nxt      = '0;
      end else begin
        res.status      = ST_FRAMING;
        prev_prefix_nxt = 1'b0;
      end
    end else if (position_r == POS_W'(1)) begin
      // ack takes priority over head
      if (rx_byte == markers.ack) begin
        res.status      = ST_ACK;
        position_nxt    = '0;
        prev_prefix_nxt = 1'b0;
      end else if (rx_byte == markers.head) begin
        position_nxt = POS_W'(2);
      end else begin
        res.status      = ST_FRAMING;
        position_nxt    = '0;
        prev_prefix_nxt = 1'b0;
      end
    end else if (position_r == POS_W'(2)) begin
      if (rx_byte == ZERO_BYTE) begin
        sum_nxt      = '0;
        position_nxt = POS_W'(3);
      end else begin
        res.status      = ST_FRAMING;
        position_nxt    = '0;
        prev_prefix_nxt = 1'b0;
      end
    end else if (pos_ext < EXT_W'(HEADER_BYTES)) begin
      if (position_r == POS_W'(3)) command_nxt = rx_byte;
      if (position_r == POS_W'(HEADER_BYTES - 1)) frame_length_nxt = rx_byte;
      sum_nxt         = sum_r + rx_byte;
      prev_prefix_nxt = 1'b0;
      position_nxt    = position_r + POS_W'(1);
    end else if (too_large) begin
      res.status      = ST_TOO_LARGE;
      position_nxt    = '0;
      prev_prefix_nxt = 1'b0;
    end else if (pos_ext < pay_end) begin
      // second prefix of a pair: drop it
      if (is_prefix && prev_prefix_r) begin
        res.status      = ST_ESCAPE;
        prev_prefix_nxt = 1'b0;
      end else begin
        res.status        = ST_PAYLOAD;
        res.payload_byte  = rx_byte;
        res.payload_index = pidx_ext[PIDX_W-1:0];
        prev_prefix_nxt   = is_prefix;
        sum_nxt           = sum_r + rx_byte;
        position_nxt      = position_r + POS_W'(1);
      end
    end else if (pos_ext == pay_end) begin
      prev_prefix_nxt = 1'b0;
      if ((sum_r + CHK_OFFSET) != rx_byte) begin
        res.status   = ST_CHECKSUM;
        position_nxt = '0;
      end else begin
        position_nxt = position_r + POS_W'(1);
      end
    end else if (pos_ext == pay_end + EXT_W'(1)) begin
      if (is_prefix) begin
        position_nxt = position_r + POS_W'(1);
      end else begin
        res.status      = ST_FRAMING;
        position_nxt    = '0;
        prev_prefix_nxt = 1'b0;
      end
    end else begin
      if (rx_byte == markers.tail) begin
        res.status         = ST_DONE;
        res.command_id     = command_r;
        res.payload_length = frame_length_r[PLEN_W-1:0];
      end else begin
        res.status = ST_FRAMING;
      end
      position_nxt    = '0;
      prev_prefix_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r     <= '0;
      frame_length_r <= '0;
      command_r      <= '0;
      sum_r          <= '0;
      prev_prefix_r  <= 1'b0;
    end else if (step_en) begin
      position_r     <= position_nxt;
      frame_length_r <= frame_length_nxt;
      command_r      <= command_nxt;
      sum_r          <= sum_nxt;
      prev_prefix_r  <= prev_prefix_nxt;
    end
  end

`ifndef SYNTH
  // errors, acks and completed frames all resynchronise
  a_resync: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (res.status == ST_ACK || res.status == ST_DONE ||
                res.status == ST_FRAMING || res.status == ST_CHECKSUM ||
                res.status == ST_TOO_LARGE)
    |=> position_r == '0)
    else $error("position not cleared after frame end or error");

  a_prefix_scope: assert property (@(posedge clk) disable iff (!rst_n)
    prev_prefix_r |-> pos_ext >= EXT_W'(HEADER_BYTES))
    else $error("escape pairing state set outside payload");

  a_payload_only: assert property (@(posedge clk) disable iff (!rst_n)
    res.status != ST_PAYLOAD |-> res.payload_byte == '0 && res.payload_index == '0)
    else $error("payload fields driven without payload status");
`endif

endmodule

>>> rtl/serial_frame_receiver_unit.sv
// Path from input transfer to result: input register, then result register.
// One byte per cycle unless stalled; the frame tracker handles a byte in one pass.
// A stalled result holds in the result register while one more byte waits in
// the input register. Synchronous active-low reset clears the frame state,
// empties both registers and restores the default marker bytes.
module serial_frame_receiver_unit
  import sfr_pkg::*;
#(
  parameter int unsigned HEADER_BYTES       = DEF_HEADER_BYTES,
  parameter int unsigned FRAME_BUFFER_BYTES = DEF_FRAME_BUFFER_BYTES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STAT_W-1:0]    out_status,
  output logic [BYTE_W-1:0]    out_payload_byte,
  output logic [PIDX_W-1:0]    out_payload_index,
  output logic [BYTE_W-1:0]    out_command_id,
  output logic [PLEN_W-1:0]    out_payload_length
);

  sfr_markers_t markers;
  sfr_result_t  res;
  sfr_result_t  out_res_r;

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              out_valid_r;
  logic              adv;
  logic              in_xfer;
  logic              step;

  // advance when the result register is empty or being taken
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;
  assign in_xfer  = in_valid && !in_stall;
  assign step     = s1_valid_r && adv;

  sfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .markers   (markers)
  );

  sfr_frame_ctrl #(
    .HEADER_BYTES       (HEADER_BYTES),
    .FRAME_BUFFER_BYTES (FRAME_BUFFER_BYTES)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step),
    .rx_byte (s1_byte_r),
    .markers (markers),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!s1_valid_r || adv) s1_valid_r <= in_valid;
      if (adv) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) s1_byte_r <= in_rx_byte;
    if (step) out_res_r <= res;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_res_r.status;
  assign out_payload_byte   = out_res_r.payload_byte;
  assign out_payload_index  = out_res_r.payload_index;
  assign out_command_id     = out_res_r.command_id;
  assign out_payload_length = out_res_r.payload_length;

endmodule

>>> tb/sfr_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the serial frame receiver: tracks each accepted byte through
// its own frame tracker and compares every result transfer in arrival order.
// Depends on sfr_pkg for widths, status codes and marker reset values.
module sfr_result_checker
  import sfr_pkg::*;
#(
  parameter int unsigned HEADER_BYTES       = DEF_HEADER_BYTES,
  parameter int unsigned FRAME_BUFFER_BYTES = DEF_FRAME_BUFFER_BYTES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [STAT_W-1:0]    out_status,
  input  logic [BYTE_W-1:0]    out_payload_byte,
  input  logic [PIDX_W-1:0]    out_payload_index,
  input  logic [BYTE_W-1:0]    out_command_id,
  input  logic [PLEN_W-1:0]    out_payload_length,
  output int                   mismatches,
  output int                   pending,
  output int                   results_checked,
  output int                   frames_done,
  output int                   error_reports
);

  localparam int REPORT_LIMIT = 10;

  sfr_markers_t      mk;
  int                frame_pos;
  logic [BYTE_W-1:0] frame_len;
  logic [BYTE_W-1:0] frame_cmd;
  logic [BYTE_W-1:0] chk_sum;
  logic              after_prefix;
  sfr_result_t       awaited_results[$];
  sfr_result_t       got;
  sfr_result_t       want;

  function automatic void restart_frame();
    frame_pos    = 0;
    after_prefix = 1'b0;
  endfunction

  // Advance the frame tracker by one byte and return the status it reports.
  function automatic sfr_result_t track_frame_byte(input logic [BYTE_W-1:0] b);
    sfr_result_t       r;
    int                pay_end;
    int                idx;
    logic [BYTE_W-1:0] sum_due;
    r        = '0;
    r.status = ST_HEADER;
    pay_end  = HEADER_BYTES + frame_len;
    if (frame_pos == 0) begin
      if (b == mk.prefix) begin
        frame_pos = 1;
        chk_sum   = '0;
      end else begin
        r.status = ST_FRAMING;
        restart_frame();
      end
    end else if (frame_pos == 1) begin
      // ack wins when it matches the head marker too
      if (b == mk.ack) begin
        r.status = ST_ACK;
        restart_frame();
      end else if (b == mk.head) begin
        frame_pos = 2;
      end else begin
        r.status = ST_FRAMING;
        restart_frame();
      end
    end else if (frame_pos == 2) begin
      if (b == ZERO_BYTE) begin
        chk_sum   = '0;
        frame_pos = 3;
      end else begin
        r.status = ST_FRAMING;
        restart_frame();
      end
    end else if (frame_pos < HEADER_BYTES) begin
      if (frame_pos == 3) frame_cmd = b;
      if (frame_pos == HEADER_BYTES - 1) frame_len = b;
      chk_sum      = chk_sum + b;
      after_prefix = 1'b0;
      frame_pos++;
    end else if (pay_end + TRAILER_BYTES > FRAME_BUFFER_BYTES) begin
      r.status = ST_TOO_LARGE;
      restart_frame();
    end else if (frame_pos < pay_end) begin
      // second of a prefix pair is dropped and does not advance the payload
      if (b == mk.prefix && after_prefix) begin
        r.status     = ST_ESCAPE;
        after_prefix = 1'b0;
      end else begin
        r.status        = ST_PAYLOAD;
        r.payload_byte  = b;
        idx             = frame_pos - HEADER_BYTES;
        r.payload_index = idx[PIDX_W-1:0];
        after_prefix    = (b == mk.prefix);
        chk_sum         = chk_sum + b;
        frame_pos++;
      end
    end else if (frame_pos == pay_end) begin
      after_prefix = 1'b0;
      sum_due      = chk_sum + CHK_OFFSET;
      if (sum_due != b) begin
        r.status = ST_CHECKSUM;
        restart_frame();
      end else begin
        frame_pos++;
      end
    end else if (frame_pos == pay_end + 1) begin
      if (b == mk.prefix) begin
        frame_pos++;
      end else begin
        r.status = ST_FRAMING;
        restart_frame();
      end
    end else begin
      if (b == mk.tail) begin
        r.status         = ST_DONE;
        r.command_id     = frame_cmd;
        r.payload_length = frame_len[PLEN_W-1:0];
      end else begin
        r.status = ST_FRAMING;
      end
      restart_frame();
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mk.prefix       = RST_PREFIX;
      mk.head         = RST_HEAD;
      mk.tail         = RST_TAIL;
      mk.ack          = RST_ACK;
      frame_len       = '0;
      frame_cmd       = '0;
      chk_sum         = '0;
      restart_frame();
      awaited_results.delete();
      mismatches      = 0;
      results_checked = 0;
      frames_done     = 0;
      error_reports   = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PREFIX: mk.prefix = cfg_wdata;
          CFG_HEAD:   mk.head   = cfg_wdata;
          CFG_TAIL:   mk.tail   = cfg_wdata;
          CFG_ACK:    mk.ack    = cfg_wdata;
          default: ;
        endcase
      end
      // check the outgoing transfer before taking in this edge's byte
      if (out_valid && !out_stall) begin
        got.status         = sfr_status_t'(out_status);
        got.payload_byte   = out_payload_byte;
        got.payload_index  = out_payload_index;
        got.command_id     = out_command_id;
        got.payload_length = out_payload_length;
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: result with status %0d arrived while none was awaited",
                     $realtime, got.status);
        end else begin
          want = awaited_results.pop_front();
          results_checked++;
          if (want.status == ST_DONE) frames_done++;
          if (want.status >= ST_FRAMING) error_reports++;
          if (got.status !== want.status || got.payload_byte !== want.payload_byte ||
              got.payload_index !== want.payload_index ||
              got.command_id !== want.command_id ||
              got.payload_length !== want.payload_length) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t: mismatch, expected st %0d byte %h idx %0d cmd %h len %0d",
                       $realtime, want.status, want.payload_byte, want.payload_index,
                       want.command_id, want.payload_length);
              $display("%0t:                got st %0d byte %h idx %0d cmd %h len %0d",
                       $realtime, got.status, got.payload_byte, got.payload_index,
                       got.command_id, got.payload_length);
            end
          end
        end
      end
      if (in_valid && !in_stall)
        awaited_results.push_back(track_frame_byte(in_rx_byte));
    end
    pending = awaited_results.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Top of the serial frame receiver testbench: clock, reset, marker writes and byte
// stimulus with bursty sending and patterned result stalls; gives the verdict.
// Depends on sfr_pkg, serial_frame_receiver_unit and sfr_result_checker.
module tb;
  import sfr_pkg::*;

  localparam int unsigned HDR         = DEF_HEADER_BYTES;
  localparam int unsigned FRAME_BUF   = DEF_FRAME_BUFFER_BYTES;
  localparam int unsigned MAX_LEN     = FRAME_BUF - HDR - TRAILER_BYTES;
  localparam int          BRK_NONE    = 0;
  localparam int          BRK_FLIP    = 1;
  localparam int          BRK_CUT     = 2;
  localparam int          HOLD_CYCLES = 60;
  localparam int          CYCLE_LIMIT = 200000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [BYTE_W-1:0]    in_rx_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic [STAT_W-1:0]    out_status;
  logic [BYTE_W-1:0]    out_payload_byte;
  logic [PIDX_W-1:0]    out_payload_index;
  logic [BYTE_W-1:0]    out_command_id;
  logic [PLEN_W-1:0]    out_payload_length;

  int mismatches;
  int pending;
  int results_checked;
  int frames_done;
  int error_reports;

  int                cycle_count   = 0;
  int                bytes_sent    = 0;
  int                burst_left    = 0;
  int                hold_requests = 0;
  int                hold_served   = 0;
  sfr_markers_t      markers_now;
  logic [BYTE_W-1:0] frame_bytes[$];
  logic [BYTE_W-1:0] payload_plan[$];

  serial_frame_receiver_unit #(
    .HEADER_BYTES      (HDR),
    .FRAME_BUFFER_BYTES(FRAME_BUF)
  ) DUT (.*);

  sfr_result_checker #(
    .HEADER_BYTES      (HDR),
    .FRAME_BUFFER_BYTES(FRAME_BUF)
  ) frame_check (.*);

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: stretches of no stall, random stall or a fixed pattern, with a
  // long hold-off whenever one is requested.
  initial begin
    int stretch;
    int mode;
    out_stall = 1'b0;
    forever begin
      stretch = $urandom_range(10, 80);
      mode    = $urandom_range(0, 2);
      for (int k = 0; k < stretch; k++) begin
        @(negedge clk);
        if (hold_served != hold_requests) begin
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES - 1) @(negedge clk);
          hold_served++;
        end else begin
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 1) == 1);
            default: out_stall <= (k % 3 == 0);
          endcase
        end
      end
    end
  end

  // Offer one byte and hold it until the transfer; valid stays high afterwards.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    wait (pending == 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_markers(input logic [BYTE_W-1:0] p, input logic [BYTE_W-1:0] h,
                             input logic [BYTE_W-1:0] t, input logic [BYTE_W-1:0] a);
    drain_results();
    write_reg(CFG_PREFIX, p);
    write_reg(CFG_HEAD, h);
    write_reg(CFG_TAIL, t);
    write_reg(CFG_ACK, a);
    markers_now.prefix = p;
    markers_now.head   = h;
    markers_now.tail   = t;
    markers_now.ack    = a;
  endtask

  // Random line byte, leaning towards the prefix so that escapes turn up often.
  function automatic logic [BYTE_W-1:0] line_byte();
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom_range(0, 255));
    return ($urandom_range(0, 4) == 0) ? markers_now.prefix : b;
  endfunction

  function automatic logic [BYTE_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return BYTE_W'($urandom_range(0, 8));
    if (r < 88) begin
      if ($urandom_range(0, 4) == 0) return BYTE_W'(MAX_LEN);
      return BYTE_W'($urandom_range(9, MAX_LEN - 1));
    end
    return BYTE_W'($urandom_range(MAX_LEN + 1, 255));
  endfunction

  task automatic send_ack();
    send_byte(markers_now.prefix);
    send_byte(markers_now.ack);
  endtask

  // Build a data frame (payload from payload_plan first, then random), escape
  // prefix bytes in pairs, optionally damage or cut it, and send it.
  task automatic send_data_frame(input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] len,
                                 input int brk);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] b;
    int                n;
    int                at;
    frame_bytes.delete();
    frame_bytes.push_back(markers_now.prefix);
    frame_bytes.push_back(markers_now.head);
    frame_bytes.push_back(ZERO_BYTE);
    frame_bytes.push_back(cmd);
    frame_bytes.push_back(len);
    sum = cmd + len;
    if (HDR + len + TRAILER_BYTES > FRAME_BUF) begin
      frame_bytes.push_back(line_byte());
    end else begin
      for (int i = 0; i < len; i++) begin
        b = (payload_plan.size() > 0) ? payload_plan.pop_front() : line_byte();
        frame_bytes.push_back(b);
        if (b == markers_now.prefix) frame_bytes.push_back(b);
        sum = sum + b;
      end
      sum = sum + CHK_OFFSET;
      frame_bytes.push_back(sum);
      frame_bytes.push_back(markers_now.prefix);
      frame_bytes.push_back(markers_now.tail);
    end
    n = frame_bytes.size();
    if (brk == BRK_FLIP) begin
      at = $urandom_range(0, n - 1);
      b  = BYTE_W'($urandom_range(1, 255));
      frame_bytes[at] = frame_bytes[at] ^ b;
    end else if (brk == BRK_CUT) begin
      n = $urandom_range(1, n - 1);
    end
    for (int i = 0; i < n; i++) send_byte(frame_bytes[i]);
  endtask

  task automatic random_traffic(input int byte_budget);
    int stop_at;
    int pick;
    stop_at = bytes_sent + byte_budget;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_data_frame(BYTE_W'($urandom_range(0, 255)), pick_length(), BRK_NONE);
      end else if (pick < 75) begin
        send_ack();
      end else if (pick < 85) begin
        send_data_frame(BYTE_W'($urandom_range(0, 255)), pick_length(),
                        (pick < 80) ? BRK_FLIP : BRK_CUT);
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(line_byte());
      end
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] shared;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_PREFIX;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_rx_byte = '0;
    markers_now.prefix = RST_PREFIX;
    markers_now.head   = RST_HEAD;
    markers_now.tail   = RST_TAIL;
    markers_now.ack    = RST_ACK;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: idle byte, acknowledge, empty frame, escaped payload, oversize
    send_byte(8'h00);
    send_ack();
    send_data_frame(8'hFF, 8'd0, BRK_NONE);
    payload_plan.push_back(markers_now.prefix);
    send_data_frame(8'h00, 8'd1, BRK_NONE);
    send_data_frame(8'h5C, BYTE_W'(MAX_LEN + 1), BRK_NONE);

    // long result hold-off while bytes keep coming, then a full drain mid-phase
    hold_requests++;
    random_traffic(60);
    drain_results();
    random_traffic(60);

    // extremes: prefix doubles as ack and as the zero byte
    set_markers(8'h00, 8'hFF, 8'hFF, 8'h00);
    random_traffic(90);

    // head equal to ack: acknowledge must win
    shared = BYTE_W'($urandom_range(0, 255));
    set_markers(BYTE_W'($urandom_range(0, 255)), shared,
                BYTE_W'($urandom_range(0, 255)), shared);
    random_traffic(35);

    set_markers(8'hFF, 8'h00, 8'h80, 8'h7F);
    hold_requests++;
    random_traffic(130);

    drain_results();
    repeat (10) @(posedge clk);
    $display("summary: %0d bytes over four marker settings, %0d results checked,",
             bytes_sent, results_checked);
    $display("summary: %0d frames completed, %0d error reports, %0d mismatches",
             frames_done, error_reports, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
